// ----- hdl/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg
// Shared widths, command and status codes for the positional list store.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int POS2_W   = 6;
  localparam int SONG_W   = 64;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 7;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SONG_W-1:0]   song_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_SWAP   = 2'd2;
  localparam cmd_t CMD_GET    = 2'd3;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_EMPTY = 3'd1;
  localparam status_t ST_RANGE = 3'd2;
  localparam status_t ST_FEW   = 3'd3;
  localparam status_t ST_FULL  = 3'd4;

endpackage

`default_nettype wire

// ----- hdl/pls_if.sv -----
// ----------------------------------------------------------------------------
// pls_req_if / pls_rsp_if
// Valid/ready channels for list requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pls_req_if;
  logic                          valid;
  logic                          ready;
  pls_pkg::cmd_t                 command;
  logic [pls_pkg::POS_W-1:0]     position;
  logic [pls_pkg::POS2_W-1:0]    second_position;
  pls_pkg::song_t                song_value;

  modport source (output valid, command, position, second_position, song_value,
                  input ready);
  modport sink   (input valid, command, position, second_position, song_value,
                  output ready);
endinterface

interface pls_rsp_if;
  logic                          valid;
  logic                          ready;
  pls_pkg::song_t                song_out;
  pls_pkg::status_t              status;
  logic [pls_pkg::LEN_W-1:0]     list_length;

  modport source (output valid, song_out, status, list_length, input ready);
  modport sink   (input valid, song_out, status, list_length, output ready);
endinterface

`default_nettype wire

// ----- hdl/pls_ram.sv -----
// ----------------------------------------------------------------------------
// pls_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/positional_list_store.sv -----
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of song handles held in one RAM; insert, remove, swap, get.
// ----------------------------------------------------------------------------
//  channel  dir  fields                                          transfer
//  req      in   command, position, second_position, song_value  valid & ready
//  rsp      out  song_out, status, list_length                   valid & ready
//
//  One request at a time. Errors and a swap of a position with itself go
//  straight to the result; an insert at the end only writes; other inserts,
//  remove and get read each entry from the position to the list end once.
//  A waiting result holds in the output register while the next request is
//  taken; completion stalls only if it still waits.
//  Synchronous reset empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  pls_req_if.sink   req,
  pls_rsp_if.source rsp
);
  import pls_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SW0  = 3'd2;
  localparam logic [2:0] S_SW1  = 3'd3;
  localparam logic [2:0] S_SW2  = 3'd4;
  localparam logic [2:0] S_SW3  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          rd_go;
  logic          v1;

  cmd_t          cmd;
  logic [AW-1:0] p1;
  logic [AW-1:0] p2;
  song_t         song;
  logic [AW-1:0] ra;
  logic [AW-1:0] last;
  logic [AW-1:0] wa;
  song_t         hold;
  song_t         res_song;
  status_t       res_status;

  logic          accept;
  logic          fin_go;
  logic [XW-1:0] p1_x;
  logic [XW-1:0] p2_x;
  logic [XW-1:0] n_x;
  status_t       st;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  song_t         ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  song_t         ram_rdata;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fin_go    = (state == S_FIN) && (!rsp.valid || rsp.ready);

  assign p1_x = XW'(req.position);
  assign p2_x = XW'(req.second_position);
  assign n_x  = XW'(count);

  always_comb begin
    st = ST_OK;
    case (req.command)
      CMD_INSERT: begin
        if (p1_x > n_x) begin
          st = ST_RANGE;
        end else if (n_x == XW'(CAPACITY)) begin
          st = ST_FULL;
        end
      end
      CMD_SWAP: begin
        if (n_x < XW'(2)) begin
          st = ST_FEW;
        end else if (p1_x >= n_x || p2_x >= n_x) begin
          st = ST_RANGE;
        end
      end
      default: begin
        if (n_x == '0) begin
          st = ST_EMPTY;
        end else if (p1_x >= n_x) begin
          st = ST_RANGE;
        end
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (res_status == ST_OK && cmd == CMD_INSERT) begin
      count_next = count + CW'(1);
    end else if (res_status == ST_OK && cmd == CMD_REMOVE) begin
      count_next = count - CW'(1);
    end
  end

  // RAM port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ra;
    ram_we    = 1'b0;
    ram_waddr = p1;
    ram_wdata = song;
    case (state)
      S_SCAN: begin
        ram_re = rd_go;
        if (v1 && cmd == CMD_INSERT) begin
          ram_we    = 1'b1;
          ram_waddr = wa + AW'(1);
          ram_wdata = ram_rdata;
        end else if (v1 && cmd == CMD_REMOVE && wa != p1) begin
          ram_we    = 1'b1;
          ram_waddr = wa - AW'(1);
          ram_wdata = ram_rdata;
        end else if (!v1 && !rd_go && cmd == CMD_INSERT) begin
          ram_we = 1'b1;
        end
      end
      S_SW0: begin
        ram_re    = 1'b1;
        ram_raddr = p1;
      end
      S_SW1: begin
        ram_re    = 1'b1;
        ram_raddr = p2;
      end
      S_SW2: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_SW3: begin
        ram_we    = 1'b1;
        ram_waddr = p2;
        ram_wdata = hold;
      end
      default: begin
      end
    endcase
  end

  pls_ram #(
    .WIDTH (SONG_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_go     <= 1'b0;
      v1        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (fin_go) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            v1 <= 1'b0;
            if (st != ST_OK) begin
              state <= S_FIN;
            end else begin
              case (req.command)
                CMD_INSERT: begin
                  rd_go <= (p1_x != n_x);
                  state <= S_SCAN;
                end
                CMD_SWAP: begin
                  state <= (p1_x == p2_x) ? S_FIN : S_SW0;
                end
                default: begin
                  rd_go <= 1'b1;
                  state <= S_SCAN;
                end
              endcase
            end
          end
        end
        S_SCAN: begin
          if (rd_go) begin
            v1 <= 1'b1;
            if (ra == ((cmd == CMD_INSERT) ? p1 : last)) begin
              rd_go <= 1'b0;
            end
          end else begin
            v1 <= 1'b0;
            if (!v1) begin
              state <= S_FIN;
            end
          end
        end
        S_SW0: state <= S_SW1;
        S_SW1: state <= S_SW2;
        S_SW2: state <= S_SW3;
        S_SW3: state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= req.command;
      p1         <= AW'(req.position);
      p2         <= AW'(req.second_position);
      song       <= req.song_value;
      res_status <= st;
      res_song   <= '0;
      last       <= AW'(count - CW'(1));
      if (req.command == CMD_INSERT) begin
        ra <= AW'(count - CW'(1));
      end else begin
        ra <= AW'(req.position);
      end
    end
    if (state == S_SCAN) begin
      if (rd_go) begin
        wa <= ra;
        ra <= (cmd == CMD_INSERT) ? ra - AW'(1) : ra + AW'(1);
      end
      if (v1 && cmd != CMD_INSERT && wa == p1) begin
        res_song <= ram_rdata;
      end
    end
    if (state == S_SW1) begin
      hold <= ram_rdata;
    end
    if (fin_go) begin
      rsp.song_out    <= res_song;
      rsp.status      <= res_status;
      rsp.list_length <= LEN_W'(count_next);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pls_checker.sv -----
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks for the positional list store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_checker #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire pls_pkg::song_t              song_out,
  input wire pls_pkg::status_t            status,
  input wire logic [pls_pkg::LEN_W-1:0]   list_length
);
  import pls_pkg::*;

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken on consecutive cycles");

  a_err_zero_song: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (song_out == '0))
    else $error("error result carries a song");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (list_length == CAP_LEN))
    else $error("full status with short list");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 127 || list_length <= CAP_LEN))
    else $error("length beyond capacity");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(song_out) &&
                                   $stable(status) && $stable(list_length)))
    else $error("stalled result changed");

endmodule

bind positional_list_store pls_checker #(
  .CAPACITY (CAPACITY)
) u_pls_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .song_out    (rsp.song_out),
  .status      (rsp.status),
  .list_length (rsp.list_length)
);

`default_nettype wire
